[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the counter core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

[design/dbcc_pkg.sv]
// ----------------------------------------------------------------------------
// Dual battery coulomb counter package
// Sequencer states, mode codes, register indexes and arithmetic constants.
// ----------------------------------------------------------------------------
package dbcc_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_Q,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_COMBINE,
    ST_PREP,
    ST_DIV_MUL,
    ST_DIV_SUB,
    ST_UPDATE,
    ST_WRITE
  } state_t;

  // Combining modes.
  typedef enum logic [1:0] {
    MODE_SUM         = 2'd0,
    MODE_A_MINUS_B   = 2'd1,
    MODE_B_MINUS_A   = 2'd2,
    MODE_INVALID     = 2'd3
  } mode_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MODE          = 2'd0;
  localparam logic [1:0] REG_OWN_INDEX     = 2'd1;
  localparam logic [1:0] REG_MONITOR_COUNT = 2'd2;

  // Integration window and energy scaling.
  localparam logic [31:0] GAP_LIMIT_US = 32'd2000000;
  localparam int unsigned NJ_DIVISOR   = 1000;
  localparam int unsigned HALF_DIVISOR = NJ_DIVISOR / 2;

  // Divider: eight 8-bit digits, each divided by 1000 through a reciprocal
  // multiply. The reciprocal ceil(2^28 / 1000) is exact for every partial
  // dividend below 2^18, which covers remainder * 256 + digit.
  localparam int unsigned        DIV_STEPS = 8;
  localparam int unsigned        DIV_SHIFT = 28;
  localparam logic signed [21:0] DIV_RECIP = 22'sd268436;

endpackage

[design/dual_battery_combine_coulomb_counter_core.sv]
// ----------------------------------------------------------------------------
// Dual battery combining coulomb counter
// Combines two battery readings by mode and integrates charge and energy.
// ----------------------------------------------------------------------------
// One item is taken at a time. A step that does not integrate (unhealthy or
// invalid configuration, currents unavailable, no previous time or a gap of
// 2 s or more) goes straight to the write state, which loads the output
// register once it is free. An integrating step makes three passes through
// the shared 25x22 signed multiplier to build the charge increment and the
// voltage-current-time product, then divides that product by 1000 to round it
// to nanojoules: eight digits, each with one reciprocal pass through the same
// multiplier and one subtract step. The input accepts a new item as soon as
// the previous result sits in the output register, even while that result waits.
module dual_battery_combine_coulomb_counter_core (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [16:0] volt_a,
  input  logic [16:0] volt_b,
  input  logic signed [20:0] curr_a,
  input  logic signed [20:0] curr_b,
  input  logic        healthy_a,
  input  logic        healthy_b,
  input  logic        curr_ok_a,
  input  logic        curr_ok_b,
  input  logic [31:0] time_us,
  // Output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic signed [18:0] voltage_out,
  output logic signed [21:0] current_out,
  output logic        current_valid,
  output logic signed [63:0] charge_mau,
  output logic signed [63:0] energy_nj
);

  import dbcc_pkg::*;

  // Configuration registers.
  mode_t       cfg_mode;
  logic [3:0]  cfg_own_index;
  logic [4:0]  cfg_monitor_count;

  // Sequencer.
  state_t      state;
  state_t      state_next;

  // Item registers.
  logic               item_ok;
  logic signed [18:0] v_r;
  logic signed [21:0] c_r;
  logic [20:0]        dt_r;

  // Held state.
  logic [31:0]        prev_time;
  logic signed [18:0] held_voltage;
  logic signed [21:0] held_current;
  logic               held_current_valid;
  logic [63:0]        charge_total;
  logic [63:0]        energy_total;

  // Multiplier and product registers.
  logic signed [24:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [46:0] prod;
  logic signed [46:0] prod_r;
  logic signed [46:0] plo_r;
  logic signed [42:0] q_r;
  logic [63:0]        p_r;
  logic [63:0]        p_sum;

  // Divider.
  logic [63:0]        dvd;
  logic [17:0]        div_y;
  logic [7:0]         div_qd;
  logic [17:0]        div_qd_x;
  logic [9:0]         div_rem;
  logic [9:0]         div_rem_next;
  logic [2:0]         div_cnt;

  // Control.
  logic               in_xfer;
  logic               out_load;
  logic               div_last;

  // Combining of the incoming item.
  logic               step_ok;
  logic               step_cv;
  logic               step_integ;
  logic signed [18:0] step_v;
  logic signed [21:0] step_c;
  logic signed [18:0] va_ext;
  logic signed [18:0] vb_ext;
  logic signed [21:0] ca_ext;
  logic signed [21:0] cb_ext;
  logic [31:0]        step_dt;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  // Registers are written in the access phase of a write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode          <= MODE_SUM;
      cfg_own_index     <= '0;
      cfg_monitor_count <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_MODE:          cfg_mode          <= mode_t'(pwdata[1:0]);
        REG_OWN_INDEX:     cfg_own_index     <= pwdata[3:0];
        REG_MONITOR_COUNT: cfg_monitor_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:          prdata = {30'b0, cfg_mode};
      REG_OWN_INDEX:     prdata = {28'b0, cfg_own_index};
      REG_MONITOR_COUNT: prdata = {27'b0, cfg_monitor_count};
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Combining of the two readings at the input transfer
  // --------------------------------------------------------------------------
  assign va_ext = signed'({2'b00, volt_a});
  assign vb_ext = signed'({2'b00, volt_b});
  assign ca_ext = {curr_a[20], curr_a};
  assign cb_ext = {curr_b[20], curr_b};

  always_comb begin
    step_ok = !(cfg_own_index < 4'd2) &&
              !({1'b0, cfg_own_index} >= cfg_monitor_count) &&
              healthy_a && healthy_b && (cfg_mode != MODE_INVALID);
    step_cv = curr_ok_a && curr_ok_b;
    unique case (cfg_mode)
      MODE_SUM: begin
        step_v = va_ext + vb_ext;
        step_c = ca_ext + cb_ext;
      end
      MODE_A_MINUS_B: begin
        step_v = va_ext - vb_ext;
        step_c = ca_ext - cb_ext;
      end
      default: begin
        step_v = vb_ext - va_ext;
        step_c = cb_ext - ca_ext;
      end
    endcase
    if (!step_cv) begin
      step_c = '0;
    end
    step_dt    = time_us - prev_time;
    step_integ = step_ok && step_cv && (prev_time != 32'd0) && (step_dt < GAP_LIMIT_US);
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = step_integ ? ST_MUL_Q : ST_WRITE;
        end
      end
      ST_MUL_Q:   state_next = ST_MUL_LO;
      ST_MUL_LO:  state_next = ST_MUL_HI;
      ST_MUL_HI:  state_next = ST_COMBINE;
      ST_COMBINE: state_next = ST_PREP;
      ST_PREP:    state_next = ST_DIV_MUL;
      ST_DIV_MUL: state_next = ST_DIV_SUB;
      ST_DIV_SUB: begin
        state_next = div_last ? ST_UPDATE : ST_DIV_MUL;
      end
      ST_UPDATE:  state_next = ST_WRITE;
      ST_WRITE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs and multiplier operand selection
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready = (state == ST_IDLE);
    out_load = (state == ST_WRITE) && (!out_valid || out_ready);
    div_last = (div_cnt == 3'(DIV_STEPS - 1));
    unique case (state)
      ST_MUL_Q: begin
        // Charge increment: current times time gap.
        mul_a = signed'({4'b0, dt_r});
        mul_b = c_r;
      end
      ST_MUL_LO: begin
        // Low 24 bits of the charge increment times voltage.
        mul_a = signed'({1'b0, prod_r[23:0]});
        mul_b = {{3{v_r[18]}}, v_r};
      end
      ST_DIV_MUL: begin
        // Partial dividend times the reciprocal of 1000.
        mul_a = signed'({7'b0, div_y});
        mul_b = DIV_RECIP;
      end
      default: begin
        // High part of the charge increment times voltage.
        mul_a = {{6{q_r[42]}}, q_r[42:24]};
        mul_b = {{3{v_r[18]}}, v_r};
      end
    endcase
  end

  assign in_xfer = in_valid && in_ready;
  assign prod    = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Held values and previous time, updated by healthy items under a valid configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time          <= '0;
      held_voltage       <= '0;
      held_current       <= '0;
      held_current_valid <= 1'b0;
    end else if (in_xfer && step_ok) begin
      prev_time          <= time_us;
      held_voltage       <= step_v;
      held_current       <= step_c;
      held_current_valid <= step_cv;
    end
  end

  // Item registers for the multiply sequence.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_ok <= step_ok;
      v_r     <= step_v;
      c_r     <= step_c;
      dt_r    <= step_dt[20:0];
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier and product assembly
  // --------------------------------------------------------------------------
  assign p_sum = {{prod_r[39:0]}, 24'b0} + {{17{plo_r[46]}}, plo_r};

  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (state == ST_MUL_LO) begin
      q_r <= prod_r[42:0];
    end
    if (state == ST_MUL_HI) begin
      plo_r <= prod_r;
    end
    if (state == ST_COMBINE) begin
      p_r <= p_sum;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: rounded magnitude over 1000, one 8-bit digit per reciprocal multiply and subtract step
  // --------------------------------------------------------------------------
  // The partial dividend is the remainder so far followed by the next digit.
  // Its quotient digit comes from the reciprocal product, and the new
  // remainder is the dividend less the digit times 1000 (1024 - 16 - 8).
  always_comb begin
    div_y        = {div_rem, dvd[63:56]};
    div_qd       = prod_r[DIV_SHIFT +: 8];
    div_qd_x     = {div_qd, 10'b0} - {6'b0, div_qd, 4'b0} - {7'b0, div_qd, 3'b0};
    div_rem_next = 10'(div_y - div_qd_x);
  end

  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      // Magnitude plus half the divisor, one add with the operand chosen by sign.
      dvd     <= p_r[63] ? (64'(HALF_DIVISOR) - p_r) : (p_r + 64'(HALF_DIVISOR));
      div_rem <= '0;
    end else if (state == ST_DIV_SUB) begin
      dvd     <= {dvd[55:0], div_qd};
      div_rem <= div_rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (state == ST_DIV_SUB) begin
      div_cnt <= div_cnt + 3'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Totals
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      charge_total <= '0;
      energy_total <= '0;
    end else begin
      if (state == ST_COMBINE) begin
        charge_total <= charge_total + {{21{q_r[42]}}, q_r};
      end
      if (state == ST_UPDATE) begin
        energy_total <= p_r[63] ? (energy_total - dvd) : (energy_total + dvd);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ok            <= item_ok;
      voltage_out   <= held_voltage;
      current_out   <= held_current;
      current_valid <= held_current_valid;
      charge_mau    <= signed'(charge_total);
      energy_nj     <= signed'(energy_total);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "assert_macros.svh"

  `ASSERT_PROP(a_busy_after_take, clk, rst, (in_valid && in_ready) |=> !in_ready, "input taken while busy")
  `ASSERT_PROP(a_result_from_write, clk, rst, $rose(out_valid) |-> $past(state == ST_WRITE), "result without write")
  `ASSERT_PROP(a_div_cnt_idle, clk, rst, ((state != ST_DIV_MUL) && (state != ST_DIV_SUB)) |-> (div_cnt == 3'd0), "divider count not cleared")
  `ASSERT_NEVER(a_div_rem_range, clk, rst, (state == ST_DIV_MUL) && (div_rem >= 10'(NJ_DIVISOR)), "remainder out of range")

endmodule
